### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Widths, constants, shared types and sequencer states of the modular
// exponentiation core.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  localparam int MOD_W = 31;
  localparam int EXP_W = 63;
  localparam int CNT_W = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);
  localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
  localparam logic [MOD_W-1:0] ONE       = MOD_W'(1);

  // request to the shared modular multiplier: prod = x * y mod m, x < m
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] prod;
  } mm_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_NEXT,
    S_MUL,
    S_SQR,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

### rtl/mexp_if.sv
// ----------------------------------------------------------------------------
// mexp_if
// Valid/ready channels of the modular exponentiation core: operand input,
// result output and modulus write.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] base;
  logic [EXP_W-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: x * y mod m over MOD_W steps, MSB of y first.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [MOD_W-1:0] m,
  input  wire mm_req_t          req,
  output mm_rsp_t               rsp
);

  logic             run_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MOD_W-1:0] r_r;
  logic [MOD_W-1:0] x_r;
  logic [MOD_W-1:0] y_r;

  logic [MOD_W+1:0] t;
  logic [MOD_W+1:0] m1;
  logic [MOD_W+1:0] m2;
  logic [MOD_W+1:0] diff;
  logic [MOD_W-1:0] r_nxt;

  // 2r + bit*x stays below 3m since r < m and x < m
  always_comb begin
    t    = {1'b0, r_r, 1'b0} + (y_r[MOD_W-1] ? {2'b00, x_r} : '0);
    m1   = {2'b00, m};
    m2   = {1'b0, m, 1'b0};
    if (t >= m2) begin
      diff = t - m2;
    end else if (t >= m1) begin
      diff = t - m1;
    end else begin
      diff = t;
    end
    r_nxt = diff[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      run_r <= 1'b1;
      cnt_r <= CNT_W'(MOD_W - 1);
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r <= '0;
      x_r <= req.x;
      y_r <= req.y;
    end else if (run_r) begin
      r_r <= r_nxt;
      y_r <= {y_r[MOD_W-2:0], 1'b0};
    end
  end

  assign rsp.done = run_r && (cnt_r == '0);
  assign rsp.prod = r_nxt;

endmodule

`default_nettype wire

### rtl/modular_exponentiation_core.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Right-to-left square-and-multiply: result = base ^ exponent mod modulus.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per operation, carrying base and exponent.
//   out_ch : one word per operation, carrying the result.
//   cfg_ch : write the modulus; always ready, write only while idle.
// Operation:
//   The base is first reduced modulo the modulus, then each exponent bit
//   costs a decision step, a multiply when the bit is set and a squaring
//   while higher bits remain. With a modulus below two the arithmetic is
//   skipped. The single bit-serial modular multiplier, 31 steps per
//   product, does all the arithmetic. One operation is in flight at a
//   time; in_ch.ready is high only while the sequencer is idle, which it
//   reenters in the same cycle that the result is posted.
// Reset:
//   rst_n clears the sequencer and the output valid and loads the modulus
//   with 1000000007.
// Stall:
//   A result holds in the output register until taken; the next word is
//   accepted meanwhile, and its finished result waits until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core
  import mexp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mexp_in_if.sink   in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink  cfg_ch
);

  state_t           state_r;
  state_t           state_nxt;
  logic [MOD_W-1:0] modulus_r;
  logic [EXP_W-1:0] e_r;
  logic [MOD_W-1:0] acc_r;
  logic [MOD_W-1:0] pw_r;
  logic             out_valid_r;
  logic [MOD_W-1:0] out_result_r;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic in_fire;
  logic mod_small;
  logic more_bits;
  logic out_free;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign mod_small = modulus_r < MOD_MIN;
  assign more_bits = e_r[EXP_W-1:1] != '0;
  assign out_free  = !out_valid_r || out_ch.ready;

  // shared multiplier
  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .m     (modulus_r),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = mod_small ? S_FINISH : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mm_rsp.done) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (e_r == '0) begin
          state_nxt = S_FINISH;
        end else if (e_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_rsp.done) state_nxt = more_bits ? S_SQR : S_FINISH;
      end
      S_SQR: begin
        if (mm_rsp.done) state_nxt = S_NEXT;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: input ready and multiplier requests
  always_comb begin
    in_ch.ready  = 1'b0;
    mm_req.start = 1'b0;
    mm_req.x     = pw_r;
    mm_req.y     = pw_r;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        // reduce the base: 1 * base mod m
        mm_req.start = in_ch.valid && !mod_small;
        mm_req.x     = ONE;
        mm_req.y     = in_ch.base;
      end
      S_NEXT: begin
        mm_req.start = e_r != '0;
        mm_req.y     = e_r[0] ? acc_r : pw_r;
      end
      S_MUL: begin
        // chain the squaring straight off the multiply
        mm_req.start = mm_rsp.done && more_bits;
      end
      S_REDUCE, S_SQR, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // modulus register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      modulus_r <= cfg_ch.data;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_fire) begin
      e_r   <= in_ch.exponent;
      acc_r <= mod_small ? '0 : ONE;
    end
    if (mm_rsp.done) begin
      if (state_r == S_REDUCE) begin
        pw_r <= mm_rsp.prod;
      end
      if (state_r == S_MUL) begin
        acc_r <= mm_rsp.prod;
      end
      if (state_r == S_SQR) begin
        pw_r <= mm_rsp.prod;
        e_r  <= {1'b0, e_r[EXP_W-1:1]};
      end
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FINISH && out_free) begin
      out_result_r <= acc_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;

  // checks
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == S_REDUCE || state_r == S_MUL || state_r == S_SQR))
    else $error("multiplier finished outside an arithmetic state");

  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEXT |-> acc_r < modulus_r)
    else $error("accumulator not reduced");

  a_pw_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_NEXT |-> pw_r < modulus_r)
    else $error("power not reduced");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("finished result not posted");

endmodule

`default_nettype wire

### sim/mexp_checker.sv
// ----------------------------------------------------------------------------
// mexp_checker
// Watches the operand, result and modulus channels of the modular
// exponentiation core, predicts each power from the accepted operand word
// and the modulus in force, and compares it with the result words in order.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_checker
  import mexp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  mexp_in_if   in_mon,
  mexp_out_if  out_mon,
  mexp_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [MOD_W-1:0] modulus_copy;
  logic [MOD_W-1:0] expected_powers [$];
  logic [MOD_W-1:0] want;
  int               mismatches = 0;

  assign fail_count = mismatches;

  // Right-to-left square-and-multiply; the base is left unreduced until
  // its first product, and every product stays below 2^62.
  function automatic logic [MOD_W-1:0] pow_mod(input logic [MOD_W-1:0] base,
                                               input logic [EXP_W-1:0] power,
                                               input logic [MOD_W-1:0] modulus);
    longint unsigned  sq;
    longint unsigned  acc;
    longint unsigned  m;
    logic [EXP_W-1:0] bits;
    m    = modulus;
    sq   = base;
    acc  = 1;
    bits = power;
    if (m < 2) return '0;
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % m;
      sq   = (sq * sq) % m;
      bits = bits >> 1;
    end
    return acc[MOD_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      modulus_copy = MOD_RESET;
      expected_powers.delete();
    end else begin
      // a modulus write takes effect before any operand of the same edge
      if (cfg_mon.valid && cfg_mon.ready) modulus_copy = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        expected_powers = {expected_powers,
                           pow_mod(in_mon.base, in_mon.exponent, modulus_copy)};
      if (out_mon.valid && out_mon.ready) begin
        if (expected_powers.size() == 0) begin
          $error("result: expected none, actual %0d", out_mon.result);
          mismatches++;
        end else begin
          want = expected_powers.pop_front();
          if (out_mon.result !== want) begin
            $error("result: expected %0d, actual %0d", want, out_mon.result);
            mismatches++;
          end
        end
      end
    end
    pending_count = expected_powers.size();
  end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the modular exponentiation core: directed corner
// operands under the reset modulus and the extreme moduli, then random
// operands over a series of random moduli with varied sender and receiver
// idling, and a long receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import mexp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Covers the slowest operation plus the long hold-off, with a wide margin.
  localparam int STALL_LIMIT = 40000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 100;
  localparam int CHUNK_WORDS = 10;

  localparam logic [MOD_W-1:0] BASE_MAX = '1;
  localparam logic [EXP_W-1:0] EXP_MAX  = '1;

  logic clk;
  logic rst_n;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();
  mexp_cfg_if cfg_ch ();

  int chk_fails;
  int chk_pending;

  // knobs shared between the stimulus and the receiver, and the watchdog count
  int               src_idle_pct = 0;
  int               snk_idle_pct = 0;
  bit               hold_req     = 1'b0;
  logic [MOD_W-1:0] cur_mod      = MOD_RESET;
  int               quiet_cycles = 0;

  modular_exponentiation_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  mexp_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (chk_fails),
    .pending_count (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("modular_exponentiation_core: mismatch");
        $finish;
      end
    end
  end

  // Receiver: drop ready at random, or for a long stretch on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // hold off so the in-flight word and the output register both fill
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Offer one operand word; start and end at a falling edge, valid left high.
  task automatic send_word(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.base     <= b;
    in_ch.exponent <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the modulus once the core has drained.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    wait (chk_pending == 0);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_mod = value;
  endtask

  function automatic logic [MOD_W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return MOD_MIN;
      2:       return MOD_W'($urandom_range(3, 1000));
      3:       return MOD_RESET;
      4:       return MOD_W'($urandom_range(0, 1));
      default: return MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
    endcase
  endfunction

  // Favor the edges: zero, one, all ones, and the modulus and its neighbor.
  function automatic logic [MOD_W-1:0] pick_base(input logic [MOD_W-1:0] m);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ONE;
      2:       return BASE_MAX;
      3:       return m - ONE;
      4:       return m;
      default: return MOD_W'($urandom);
    endcase
  endfunction

  // Random bit length up to max_len, top bit set, sometimes all ones.
  function automatic logic [EXP_W-1:0] pick_exponent(input int max_len);
    int          len;
    logic [63:0] bits;
    logic [63:0] mask;
    len  = $urandom_range(0, max_len);
    bits = {$urandom, $urandom};
    mask = (64'd1 << len) - 64'd1;
    if (len == 0) return '0;
    if ($urandom_range(0, 7) == 0) bits = mask;
    else bits = (bits & mask) | (64'd1 << (len - 1));
    return bits[EXP_W-1:0];
  endfunction

  task automatic run_words(input int count, input int max_len);
    for (int i = 0; i < count; i++) send_word(pick_base(cur_mod), pick_exponent(max_len));
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.base      <= '0;
    in_ch.exponent  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset modulus, no write yet.
    send_word('0, '0);                           // zero to the zero gives one
    send_word('0, EXP_W'(5));
    send_word(BASE_MAX, '0);
    send_word(BASE_MAX, EXP_MAX);
    send_word(ONE, EXP_MAX);
    send_word(MOD_W'(2), EXP_W'(1));
    send_word(BASE_MAX, EXP_W'(1));              // base above the modulus
    send_word(MOD_RESET, EXP_W'(3));             // base equal to the modulus
    send_word(MOD_RESET - ONE, EXP_W'(2));
    send_word(MOD_W'(2), EXP_W'(1) << (EXP_W - 1));
    send_word(MOD_W'(3), EXP_W'({(EXP_W+1)/2{2'b01}}));
    send_word(MOD_W'(7), EXP_W'({(EXP_W+1)/2{2'b10}}));
    send_word(MOD_W'(12345), EXP_W'(62));
    in_ch.valid <= 1'b0;

    // Largest modulus.
    write_modulus('1);
    send_word(BASE_MAX, EXP_W'(5));
    send_word(BASE_MAX - ONE, EXP_W'(2));
    send_word(MOD_W'(3), EXP_MAX);
    in_ch.valid <= 1'b0;

    // Smallest legal modulus.
    write_modulus(MOD_MIN);
    send_word(BASE_MAX, EXP_MAX);
    send_word(BASE_MAX - ONE, EXP_W'(7));
    in_ch.valid <= 1'b0;

    // Modulus below two: every result is zero, zero exponent included.
    write_modulus(ONE);
    send_word(MOD_W'(5), '0);
    send_word(BASE_MAX, EXP_MAX);
    in_ch.valid <= 1'b0;
    write_modulus('0);
    send_word('0, '0);
    send_word(MOD_W'(9), EXP_W'(9));
    in_ch.valid <= 1'b0;

    // Random words: receiver-heavy idling, then sender-heavy, then none.
    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 18 : (p == 1) ? 78 : 0;
      snk_idle_pct = (p == 0) ? 78 : (p == 1) ? 18 : 0;
      for (int c = 0; c < 4; c++) begin
        write_modulus(pick_modulus());
        run_words(CHUNK_WORDS, EXP_W);
      end
    end

    // Back the core up: hold the receiver while short words keep coming.
    write_modulus(MOD_W'($urandom_range(2, 32'h7FFF_FFFF)));
    hold_req = 1'b1;
    run_words(6, 8);

    // Drain, then watch a while for stray result words.
    wait (chk_pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("modular_exponentiation_core: match");
    end else begin
      $display("modular_exponentiation_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/mexp_pkg.sv
rtl/mexp_if.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation_core.sv
sim/mexp_checker.sv
sim/tb_top.sv
